[hw/rtl/sct_pkg.sv]
package sct_pkg;

    localparam int unsigned DEF_SERIES_TERMS = 12;
    localparam int unsigned DEF_FRAC_BITS    = 30;
    localparam int unsigned DEF_ANGLE_WIDTH  = 32;

    localparam int unsigned VALUE_WIDTH = 32;
    localparam int unsigned VALUE_FRAC  = 30;

    // integer guard bits over the fraction for each datapath word
    localparam int unsigned TERM_GUARD = 4;
    localparam int unsigned SUM_GUARD  = 5;
    localparam int unsigned SQ_GUARD   = 4;
    localparam int unsigned PROD_GUARD = 8;

    // pi in Q4.60
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    typedef enum logic {
        OP_SINE   = 1'b0,
        OP_COSINE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic    valid;
        t_opcode op;
    } t_lane_ctl;

endpackage

[hw/rtl/sct_if.sv]
interface sct_in_if #(
    parameter int unsigned ANGLE_WIDTH = sct_pkg::DEF_ANGLE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, output opcode, output angle, input ready);
    modport sink   (input valid, input opcode, input angle, output ready);
endinterface

interface sct_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sct_pkg::VALUE_WIDTH-1:0] value;
    logic                                  clipped;

    modport source (output valid, output value, output clipped, input ready);
    modport sink   (input valid, input value, input clipped, output ready);
endinterface

[hw/rtl/sct_term_step.sv]
module sct_term_step #(
    parameter int unsigned FRAC_BITS = sct_pkg::DEF_FRAC_BITS,
    parameter int unsigned STEP      = 1
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  sct_pkg::t_lane_ctl                                     i_ctl,
    output logic                                                   o_ready,
    input  logic signed [FRAC_BITS+sct_pkg::SUM_GUARD-1:0]         i_sum,
    input  logic signed [FRAC_BITS+sct_pkg::TERM_GUARD-1:0]        i_term,
    input  logic        [FRAC_BITS+sct_pkg::SQ_GUARD-1:0]          i_x2,
    output sct_pkg::t_lane_ctl                                     o_ctl,
    input  logic                                                   i_ready,
    output logic signed [FRAC_BITS+sct_pkg::SUM_GUARD-1:0]         o_sum,
    output logic signed [FRAC_BITS+sct_pkg::TERM_GUARD-1:0]        o_term,
    output logic        [FRAC_BITS+sct_pkg::SQ_GUARD-1:0]          o_x2
);
    import sct_pkg::*;

    localparam int unsigned T_W  = FRAC_BITS + TERM_GUARD;
    localparam int unsigned S_W  = FRAC_BITS + SUM_GUARD;
    localparam int unsigned X2_W = FRAC_BITS + SQ_GUARD;
    localparam int unsigned P_W  = FRAC_BITS + PROD_GUARD;

    localparam logic [63:0] ONE_64 = 64'd1 << FRAC_BITS;
    localparam logic [63:0] D_SIN  = 64'((2 * STEP) * (2 * STEP + 1));
    localparam logic [63:0] D_COS  = 64'((2 * STEP - 1) * (2 * STEP));
    localparam logic [FRAC_BITS-1:0] K_SIN = FRAC_BITS'((ONE_64 + D_SIN / 2) / D_SIN);
    localparam logic [FRAC_BITS-1:0] K_COS = FRAC_BITS'((ONE_64 + D_COS / 2) / D_COS);

    // stage a: term * x^2, running sum picks up the incoming term
    t_lane_ctl               r_a_ctl;
    logic signed [P_W-1:0]   r_a_p;
    logic signed [S_W-1:0]   r_a_sum;
    logic        [X2_W-1:0]  r_a_x2;
    logic                    a_rdy;

    logic signed [X2_W:0]      x2s;
    logic signed [T_W+X2_W:0]  prod_a;
    logic signed [P_W-1:0]     n_a_p;
    logic signed [S_W-1:0]     n_a_sum;

    assign x2s     = {1'b0, i_x2};
    assign prod_a  = i_term * x2s;
    assign n_a_p   = prod_a[FRAC_BITS+P_W-1:FRAC_BITS];
    assign n_a_sum = i_sum + S_W'(i_term);

    // stage b: scale by the reciprocal and flip the sign
    t_lane_ctl               r_b_ctl;
    logic signed [T_W-1:0]   r_b_term;
    logic signed [S_W-1:0]   r_b_sum;
    logic        [X2_W-1:0]  r_b_x2;

    logic signed [FRAC_BITS:0]     kk;
    logic signed [P_W+FRAC_BITS:0] prod_b;
    logic signed [T_W-1:0]         t_scaled;
    logic signed [T_W-1:0]         n_b_term;

    assign kk       = (r_a_ctl.op == OP_COSINE) ? {1'b0, K_COS} : {1'b0, K_SIN};
    assign prod_b   = r_a_p * kk;
    assign t_scaled = prod_b[FRAC_BITS+T_W-1:FRAC_BITS];
    assign n_b_term = -t_scaled;

    assign a_rdy   = !r_b_ctl.valid || i_ready;
    assign o_ready = !r_a_ctl.valid || a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (o_ready) begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_a_p   <= n_a_p;
            r_a_sum <= n_a_sum;
            r_a_x2  <= i_x2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (a_rdy) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && r_a_ctl.valid) begin
            r_b_term <= n_b_term;
            r_b_sum  <= r_a_sum;
            r_b_x2   <= r_a_x2;
        end
    end

    assign o_ctl  = r_b_ctl;
    assign o_sum  = r_b_sum;
    assign o_term = r_b_term;
    assign o_x2   = r_b_x2;

endmodule

[hw/rtl/sine_cosine_taylor_unit.sv]
// Sine or cosine of a signed Q4.28 angle, one beat in per clock while ready is high, result in
// Q2.30 saturated to plus or minus one with a clip flag. The pipeline registers the angle after
// alignment and the single 2pi correction, then x squared, then for each series term the term
// times x squared and that product times the rounded reciprocal (each with its own multiplier and
// register), and last the final add and saturation. Every stage has its own valid bit and
// ready is formed stage by stage, so a stalled output holds its beat while empty stages
// behind it keep taking new angles.
module sine_cosine_taylor_unit #(
    parameter int unsigned SERIES_TERMS = sct_pkg::DEF_SERIES_TERMS,
    parameter int unsigned FRAC_BITS    = sct_pkg::DEF_FRAC_BITS,
    parameter int unsigned ANGLE_WIDTH  = sct_pkg::DEF_ANGLE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sct_in_if.sink     i_in,
    sct_out_if.source  o_out
);
    import sct_pkg::*;

    localparam int unsigned ANGLE_FRAC = ANGLE_WIDTH - 4;
    localparam int unsigned SHL  = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
    localparam int unsigned SHR  = (FRAC_BITS >= ANGLE_FRAC) ? 0 : ANGLE_FRAC - FRAC_BITS;
    localparam int unsigned A_W  = ANGLE_WIDTH + SHL + 1;
    localparam int unsigned X_W  = FRAC_BITS + 5;
    localparam int unsigned R_W  = FRAC_BITS + 3;
    localparam int unsigned T_W  = FRAC_BITS + TERM_GUARD;
    localparam int unsigned S_W  = FRAC_BITS + SUM_GUARD;
    localparam int unsigned X2_W = FRAC_BITS + SQ_GUARD;
    localparam int unsigned SAT_W     = FRAC_BITS + 2;
    localparam int unsigned VAL_SHIFT = VALUE_FRAC - FRAC_BITS;

    localparam logic [63:0] PI_RND =
        (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_RND =
        (PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);

    localparam logic signed [X_W-1:0]   PI_X     = X_W'(PI_RND);
    localparam logic signed [X_W-1:0]   TWO_PI_X = X_W'(TWO_PI_RND);
    localparam logic signed [R_W-1:0]   PI_R     = R_W'(PI_RND);
    localparam logic signed [T_W-1:0]   ONE_T    = T_W'(64'd1 << FRAC_BITS);
    localparam logic signed [S_W-1:0]   ONE_S    = S_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] ONE_SAT  = SAT_W'(64'd1 << FRAC_BITS);
    localparam logic signed [VALUE_WIDTH-1:0] ONE_OUT = VALUE_WIDTH'(64'd1 << VALUE_FRAC);

    // stage 1: align to the working fraction and fold into plus or minus pi
    logic                  r_s1_v;
    t_opcode               r_s1_op;
    logic signed [R_W-1:0] r_s1_x;
    logic                  s1_rdy;

    logic signed [A_W-1:0] a_wide;
    logic signed [X_W-1:0] x_al;
    logic signed [X_W-1:0] x_red;

    assign a_wide = (A_W'($signed(i_in.angle[ANGLE_WIDTH-1:0])) <<< SHL) >>> SHR;
    assign x_al   = a_wide[X_W-1:0];

    always_comb begin
        priority if (x_al > PI_X) begin
            x_red = x_al - TWO_PI_X;
        end else if (x_al < -PI_X) begin
            x_red = x_al + TWO_PI_X;
        end else begin
            x_red = x_al;
        end
    end

    // stage 2: x squared and the first term
    t_lane_ctl              r_s2_ctl;
    logic signed [S_W-1:0]  r_s2_sum;
    logic signed [T_W-1:0]  r_s2_term;
    logic        [X2_W-1:0] r_s2_x2;
    logic                   s2_rdy;

    logic signed [2*R_W-1:0] sq;

    assign sq = r_s1_x * r_s1_x;

    // links between the term steps, index 0 is fed by stage 2
    t_lane_ctl              lnk_ctl  [SERIES_TERMS+1];
    logic                   lnk_rdy  [SERIES_TERMS+1];
    logic signed [S_W-1:0]  lnk_sum  [SERIES_TERMS+1];
    logic signed [T_W-1:0]  lnk_term [SERIES_TERMS+1];
    logic        [X2_W-1:0] lnk_x2   [SERIES_TERMS+1];

    assign s2_rdy = !r_s2_ctl.valid || lnk_rdy[0];
    assign s1_rdy = !r_s1_v || s2_rdy;
    assign i_in.ready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_in.valid) begin
            r_s1_op <= t_opcode'(i_in.opcode);
            r_s1_x  <= x_red[R_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (s2_rdy) begin
            r_s2_ctl.valid <= r_s1_v;
            r_s2_ctl.op    <= r_s1_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_v) begin
            r_s2_sum  <= '0;
            r_s2_term <= (r_s1_op == OP_COSINE) ? ONE_T : T_W'(r_s1_x);
            r_s2_x2   <= sq[FRAC_BITS+X2_W-1:FRAC_BITS];
        end
    end

    assign lnk_ctl[0]  = r_s2_ctl;
    assign lnk_sum[0]  = r_s2_sum;
    assign lnk_term[0] = r_s2_term;
    assign lnk_x2[0]   = r_s2_x2;

    for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_step
        sct_term_step #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (g + 1)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lnk_ctl[g]),
            .o_ready (lnk_rdy[g]),
            .i_sum   (lnk_sum[g]),
            .i_term  (lnk_term[g]),
            .i_x2    (lnk_x2[g]),
            .o_ctl   (lnk_ctl[g+1]),
            .i_ready (lnk_rdy[g+1]),
            .o_sum   (lnk_sum[g+1]),
            .o_term  (lnk_term[g+1]),
            .o_x2    (lnk_x2[g+1])
        );
    end

    // output stage: last add and saturation
    logic                          r_o_v;
    logic signed [VALUE_WIDTH-1:0] r_o_value;
    logic                          r_o_clip;

    logic signed [S_W-1:0]         total;
    logic signed [SAT_W-1:0]       sat;
    logic                          n_clip;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          out_rdy;

    assign total = lnk_sum[SERIES_TERMS] + S_W'(lnk_term[SERIES_TERMS]);

    always_comb begin
        priority if (total > ONE_S) begin
            sat    = ONE_SAT;
            n_clip = 1'b1;
        end else if (total < -ONE_S) begin
            sat    = -ONE_SAT;
            n_clip = 1'b1;
        end else begin
            sat    = total[SAT_W-1:0];
            n_clip = 1'b0;
        end
    end

    assign n_value = VALUE_WIDTH'(sat) <<< VAL_SHIFT;

    assign out_rdy = !r_o_v || o_out.ready;
    assign lnk_rdy[SERIES_TERMS] = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_rdy) begin
            r_o_v <= lnk_ctl[SERIES_TERMS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && lnk_ctl[SERIES_TERMS].valid) begin
            r_o_value <= n_value;
            r_o_clip  <= n_clip;
        end
    end

    assign o_out.valid   = r_o_v;
    assign o_out.value   = r_o_value;
    assign o_out.clipped = r_o_clip;

    a_reduced_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (r_s1_x <= PI_R && r_s1_x >= -PI_R))
        else $error("reduced angle outside plus or minus pi");

    a_value_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.value <= ONE_OUT && o_out.value >= -ONE_OUT))
        else $error("result beat outside plus or minus one");

    a_clip_at_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clipped) |-> (o_out.value == ONE_OUT || o_out.value == -ONE_OUT))
        else $error("clipped beat not at a rail");

endmodule
